[rtl/core/rcvs_pkg.sv]
// ============================================================================
// rcvs_pkg
// Shared types, register indexes and table helpers of the velocity shaper.
// ============================================================================
package rcvs_pkg;

    localparam int REG_W  = 15;
    localparam int DATA_W = 16;

    typedef enum logic [2:0] {
        CFG_DIST_HIGH     = 3'd0,
        CFG_DIST_LOW      = 3'd1,
        CFG_SPEED_MAX     = 3'd2,
        CFG_SPEED_MIN     = 3'd3,
        CFG_TURN_RATE_MAX = 3'd4,
        CFG_TURN_RATE_MIN = 3'd5,
        CFG_ANGLE_HIGH    = 3'd6,
        CFG_ANGLE_LOW     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [REG_W-1:0] dist_high;
        logic [REG_W-1:0] dist_low;
        logic [REG_W-1:0] speed_max;
        logic [REG_W-1:0] speed_min;
        logic [REG_W-1:0] turn_rate_max;
        logic [REG_W-1:0] turn_rate_min;
        logic [REG_W-1:0] angle_high;
        logic [REG_W-1:0] angle_low;
    } cfg_t;

    typedef enum logic [1:0] {
        SC_ZERO = 2'd0,
        SC_MAX  = 2'd1,
        SC_MIN  = 2'd2,
        SC_RAMP = 2'd3
    } shape_class_t;

    // One classified command as it travels from the front to the back end.
    typedef struct packed {
        logic              x_neg;
        logic              y_neg;
        logic              yaw_neg;
        logic [DATA_W-1:0] x_abs;
        logic [DATA_W-1:0] y_abs;
        logic [DATA_W-1:0] mag;
        shape_class_t      t_class;
        logic [REG_W-1:0]  t_ofs;
        logic [REG_W-1:0]  t_span;
        shape_class_t      a_class;
        logic [REG_W-1:0]  a_ofs;
        logic [REG_W-1:0]  a_span;
    } rcvs_item_t;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint unsigned TAYLOR_DIV [10] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

    // Cosine in Q30 of an angle in [0, pi/2], ten Taylor terms.
    function automatic longint rcvs_cos_q30(input longint unsigned ang);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x2   = (ang * ang) >> 30;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        for (int k = 0; k < 10; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k[0] == 1'b0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        return sum;
    endfunction

    // Raised-cosine table entry i for a table of 2^cb steps and sb fraction bits.
    function automatic logic [31:0] rcvs_table_entry(input int unsigned cb,
                                                     input int unsigned sb,
                                                     input int unsigned i);
        longint unsigned ang;
        longint          c;
        longint          tmp;
        longint          w;
        longint unsigned rounded;
        ang = (PI_Q30 * longint'(i)) >> cb;
        if (ang > (PI_Q30 >> 1)) begin
            c = -rcvs_cos_q30(PI_Q30 - ang);
        end else begin
            c = rcvs_cos_q30(ang);
        end
        tmp = longint'(ONE_Q30) - c;
        if (tmp < 0) begin
            w = 0;
        end else begin
            w = tmp >>> 1;
        end
        if (w > longint'(ONE_Q30)) begin
            w = longint'(ONE_Q30);
        end
        rounded = (longint'(w) + (64'd1 << (29 - sb))) >> (30 - sb);
        return rounded[31:0];
    endfunction

endpackage

[rtl/core/rcvs_ram.sv]
// ============================================================================
// rcvs_ram
// Generic single write port RAM with one registered read port.
// ============================================================================
module rcvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1025
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/rcvs_div.sv]
// ============================================================================
// rcvs_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module rcvs_div #(
    parameter int NW = 25,
    parameter int DW = 15,
    parameter int QW = 11,
    parameter int PW = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [1:0][NW-1:0]    num_i,
    input  logic [1:0][DW-1:0]    den_i,
    input  logic [PW-1:0]         side_i,
    output logic                  out_valid,
    output logic [1:0][QW-1:0]    quo_o,
    output logic [1:0][DW-1:0]    rem_o,
    output logic [PW-1:0]         side_o
);

    // The caller guarantees num < den * 2^QW, so the upper part starts below den.
    logic                 v_reg    [1:QW];
    logic [1:0][DW-1:0]   rem_reg  [1:QW];
    logic [1:0][DW-1:0]   den_reg  [1:QW];
    logic [1:0][QW-1:0]   q_reg    [1:QW];
    logic [1:0][QW-1:0]   low_reg  [1:QW];
    logic [PW-1:0]        side_reg [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic                 v_src;
        logic [1:0][DW-1:0]   rem_src;
        logic [1:0][DW-1:0]   den_src;
        logic [1:0][QW-1:0]   q_src;
        logic [1:0][QW-1:0]   low_src;
        logic [PW-1:0]        s_src;
        logic [1:0][DW-1:0]   rem_next;
        logic [1:0][QW-1:0]   q_next;
        logic [1:0][QW-1:0]   low_next;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < 2; l++) begin
                    rem_src[l] = DW'(num_i[l] >> QW);
                    low_src[l] = num_i[l][QW-1:0];
                    q_src[l]   = '0;
                end
            end
            assign v_src   = in_valid;
            assign den_src = den_i;
            assign s_src   = side_i;
        end else begin : g_rest
            assign v_src   = v_reg[k];
            assign rem_src = rem_reg[k];
            assign den_src = den_reg[k];
            assign q_src   = q_reg[k];
            assign low_src = low_reg[k];
            assign s_src   = side_reg[k];
        end

        always_comb begin
            logic [DW:0] cur;
            logic        ge;
            for (int l = 0; l < 2; l++) begin
                cur = {rem_src[l], low_src[l][QW-1]};
                ge  = (cur >= {1'b0, den_src[l]});
                rem_next[l] = ge ? DW'(cur - {1'b0, den_src[l]}) : DW'(cur);
                q_next[l]   = (q_src[l] << 1) | QW'(ge);
                low_next[l] = low_src[l] << 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rem_next;
                den_reg[k+1]  <= den_src;
                q_reg[k+1]    <= q_next;
                low_reg[k+1]  <= low_next;
                side_reg[k+1] <= s_src;
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign quo_o     = q_reg[QW];
    assign rem_o     = rem_reg[QW];
    assign side_o    = side_reg[QW];

endmodule

[rtl/core/rcvs_front.sv]
// ============================================================================
// rcvs_front
// Front end: magnitudes, pipelined integer square root and classification.
// ============================================================================
module rcvs_front
    import rcvs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] in_x,
    input  logic signed [DATA_W-1:0] in_y,
    input  logic signed [DATA_W-1:0] in_yaw,
    output logic                     out_valid,
    input  logic                     out_ready,
    output rcvs_item_t               out_item
);

    localparam int ROOT_STEPS = DATA_W;

    typedef struct packed {
        logic              valid;
        logic              x_neg;
        logic              y_neg;
        logic              yaw_neg;
        logic [DATA_W-1:0] x_abs;
        logic [DATA_W-1:0] y_abs;
        logic [DATA_W-1:0] a;
    } side_t;

    function automatic shape_class_t classify(input logic [DATA_W-1:0] v,
                                              input logic [REG_W-1:0]  hi,
                                              input logic [REG_W-1:0]  lo);
        shape_class_t sc;
        if (v == '0) begin
            sc = SC_ZERO;
        end else if (v > {1'b0, hi}) begin
            sc = SC_MAX;
        end else if (v < {1'b0, lo}) begin
            sc = SC_MIN;
        end else if (hi == lo) begin
            sc = SC_MAX;
        end else begin
            sc = SC_RAMP;
        end
        return sc;
    endfunction

    logic en;

    logic                     s1_valid_reg;
    logic signed [DATA_W-1:0] s1_x_reg;
    logic signed [DATA_W-1:0] s1_y_reg;
    logic signed [DATA_W-1:0] s1_yaw_reg;

    side_t                  side_reg [0:ROOT_STEPS];
    logic [2*DATA_W-1:0]    rad_reg  [0:ROOT_STEPS];
    logic [DATA_W+1:0]      rem_reg  [0:ROOT_STEPS];
    logic [DATA_W-1:0]      root_reg [0:ROOT_STEPS];

    logic       item_valid_reg;
    rcvs_item_t item_reg;

    logic [DATA_W-1:0]   x_abs;
    logic [DATA_W-1:0]   y_abs;
    logic [DATA_W-1:0]   yaw_abs;
    logic [2*DATA_W-1:0] sq_sum;

    assign en       = !item_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_x_reg   <= in_x;
            s1_y_reg   <= in_y;
            s1_yaw_reg <= in_yaw;
        end
    end

    // The most negative value maps to 32768, which still fits unsigned.
    always_comb begin
        x_abs   = s1_x_reg[DATA_W-1] ? (~s1_x_reg + 1'b1) : s1_x_reg;
        y_abs   = s1_y_reg[DATA_W-1] ? (~s1_y_reg + 1'b1) : s1_y_reg;
        yaw_abs = s1_yaw_reg[DATA_W-1] ? (~s1_yaw_reg + 1'b1) : s1_yaw_reg;
        sq_sum  = {{DATA_W{1'b0}}, x_abs} * {{DATA_W{1'b0}}, x_abs}
                + {{DATA_W{1'b0}}, y_abs} * {{DATA_W{1'b0}}, y_abs};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg[0].valid <= 1'b0;
        end else if (en) begin
            side_reg[0].valid <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0].x_neg   <= s1_x_reg[DATA_W-1];
            side_reg[0].y_neg   <= s1_y_reg[DATA_W-1];
            side_reg[0].yaw_neg <= s1_yaw_reg[DATA_W-1];
            side_reg[0].x_abs   <= x_abs;
            side_reg[0].y_abs   <= y_abs;
            side_reg[0].a       <= yaw_abs;
            rad_reg[0]          <= sq_sum;
            rem_reg[0]          <= '0;
            root_reg[0]         <= '0;
        end
    end

    // Each stage brings down two radicand bits and settles one root bit.
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        logic [DATA_W+3:0] cur;
        logic [DATA_W+3:0] trial;
        logic              ge;

        always_comb begin
            cur   = {rem_reg[k], rad_reg[k][2*DATA_W-1 -: 2]};
            trial = {2'b00, root_reg[k], 2'b01};
            ge    = (cur >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[k+1].valid <= 1'b0;
            end else if (en) begin
                side_reg[k+1].valid <= side_reg[k].valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1].x_neg   <= side_reg[k].x_neg;
                side_reg[k+1].y_neg   <= side_reg[k].y_neg;
                side_reg[k+1].yaw_neg <= side_reg[k].yaw_neg;
                side_reg[k+1].x_abs   <= side_reg[k].x_abs;
                side_reg[k+1].y_abs   <= side_reg[k].y_abs;
                side_reg[k+1].a       <= side_reg[k].a;
                rad_reg[k+1]  <= rad_reg[k] << 2;
                rem_reg[k+1]  <= ge ? (DATA_W+2)'(cur - trial) : (DATA_W+2)'(cur);
                root_reg[k+1] <= {root_reg[k][DATA_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (en) begin
            item_valid_reg <= side_reg[ROOT_STEPS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg.x_neg   <= side_reg[ROOT_STEPS].x_neg;
            item_reg.y_neg   <= side_reg[ROOT_STEPS].y_neg;
            item_reg.yaw_neg <= side_reg[ROOT_STEPS].yaw_neg;
            item_reg.x_abs   <= side_reg[ROOT_STEPS].x_abs;
            item_reg.y_abs   <= side_reg[ROOT_STEPS].y_abs;
            item_reg.mag     <= root_reg[ROOT_STEPS];
            item_reg.t_class <= classify(root_reg[ROOT_STEPS], cfg.dist_high, cfg.dist_low);
            item_reg.t_ofs   <= REG_W'(root_reg[ROOT_STEPS] - {1'b0, cfg.dist_low});
            item_reg.t_span  <= cfg.dist_high - cfg.dist_low;
            item_reg.a_class <= classify(side_reg[ROOT_STEPS].a, cfg.angle_high,
                                         cfg.angle_low);
            item_reg.a_ofs   <= REG_W'(side_reg[ROOT_STEPS].a - {1'b0, cfg.angle_low});
            item_reg.a_span  <= cfg.angle_high - cfg.angle_low;
        end
    end

    assign out_valid = item_valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/core/rcvs_fifo.sv]
// ============================================================================
// rcvs_fifo
// Short register queue between the front and back ends.
// ============================================================================
module rcvs_fifo
    import rcvs_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  rcvs_item_t din,
    output logic       full,
    input  logic       pop,
    output rcvs_item_t dout,
    output logic       empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rcvs_item_t      mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[rtl/core/rcvs_back.sv]
// ============================================================================
// rcvs_back
// Back end: ramp position, table interpolation, speed mapping and rescale.
// ============================================================================
module rcvs_back
    import rcvs_pkg::*;
#(
    parameter int CB = 10,
    parameter int SB = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    output logic              table_ready,
    input  logic              q_empty,
    input  rcvs_item_t        q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_x,
    output logic [DATA_W-1:0] out_y,
    output logic [DATA_W-1:0] out_yaw
);

    localparam int N   = 1 << CB;
    localparam int AW  = CB + 1;
    localparam int TW  = SB + 1;
    localparam int NW1 = REG_W + CB;
    localparam int NW2 = TW + REG_W;
    localparam int PW3 = 2 * DATA_W - 1;

    typedef logic [TW-1:0] tab_t [0:N];

    function automatic tab_t build_tab();
        tab_t t;
        for (int i = 0; i <= N; i++) begin
            t[i] = TW'(rcvs_table_entry(CB, SB, i));
        end
        return t;
    endfunction

    localparam tab_t RC_TAB = build_tab();

    typedef struct packed {
        rcvs_item_t    item;
        logic [TW-1:0] lo_t;
        logic [TW-1:0] lo_a;
    } side2_t;

    typedef struct packed {
        logic              x_neg;
        logic              y_neg;
        logic              m_zero;
        logic [DATA_W-1:0] yaw;
    } side3_t;

    logic en;

    // Table load after reset.
    logic          filling_reg;
    logic [AW-1:0] fill_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filling_reg  <= 1'b1;
            fill_cnt_reg <= '0;
        end else if (filling_reg) begin
            fill_cnt_reg <= fill_cnt_reg + 1'b1;
            if (fill_cnt_reg == AW'(N)) begin
                filling_reg <= 1'b0;
            end
        end
    end

    assign table_ready = !filling_reg;

    assign en    = !out_valid || out_ready;
    assign q_pop = en && !q_empty;

    // Queue output register.
    logic       b0_valid_reg;
    rcvs_item_t b0_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_valid_reg <= 1'b0;
        end else if (en) begin
            b0_valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b0_item_reg <= q_item;
        end
    end

    // Table index and fraction: (ofs * N) / span.
    logic                 d1_valid;
    logic [1:0][AW-1:0]   d1_quo;
    logic [1:0][REG_W-1:0] d1_rem;
    rcvs_item_t           d1_item;

    rcvs_div #(.NW(NW1), .DW(REG_W), .QW(AW), .PW($bits(rcvs_item_t))) u_div_pos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b0_valid_reg),
        .num_i     ({{b0_item_reg.a_ofs, {CB{1'b0}}}, {b0_item_reg.t_ofs, {CB{1'b0}}}}),
        .den_i     ({b0_item_reg.a_span, b0_item_reg.t_span}),
        .side_i    (b0_item_reg),
        .out_valid (d1_valid),
        .quo_o     (d1_quo),
        .rem_o     (d1_rem),
        .side_o    (d1_item)
    );

    logic [1:0][AW-1:0] next_addr;
    logic [1:0][TW-1:0] lo_e;
    logic [1:0][TW-1:0] hi_e;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            next_addr[l] = (d1_quo[l] == AW'(N)) ? d1_quo[l] : d1_quo[l] + 1'b1;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_tab
        rcvs_ram #(.WIDTH(TW), .DEPTH(N + 1)) u_ram_lo (
            .aclk  (aclk),
            .we    (filling_reg),
            .waddr (fill_cnt_reg),
            .wdata (RC_TAB[fill_cnt_reg]),
            .re    (en),
            .raddr (d1_quo[l]),
            .rdata (lo_e[l])
        );
        rcvs_ram #(.WIDTH(TW), .DEPTH(N + 1)) u_ram_hi (
            .aclk  (aclk),
            .we    (filling_reg),
            .waddr (fill_cnt_reg),
            .wdata (RC_TAB[fill_cnt_reg]),
            .re    (en),
            .raddr (next_addr[l]),
            .rdata (hi_e[l])
        );
    end

    logic                  b1_valid_reg;
    rcvs_item_t            b1_item_reg;
    logic [1:0][REG_W-1:0] b1_rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
        end else if (en) begin
            b1_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_item_reg <= d1_item;
            b1_rem_reg  <= d1_rem;
        end
    end

    // Interpolation step times fraction.
    logic                b2_valid_reg;
    rcvs_item_t          b2_item_reg;
    logic [1:0][NW2-1:0] b2_prod_reg;
    logic [1:0][TW-1:0]  b2_lo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg <= 1'b0;
        end else if (en) begin
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [TW-1:0] diff;
        if (en) begin
            b2_item_reg <= b1_item_reg;
            b2_lo_reg   <= lo_e;
            for (int l = 0; l < 2; l++) begin
                diff = (hi_e[l] >= lo_e[l]) ? hi_e[l] - lo_e[l] : '0;
                b2_prod_reg[l] <= {{REG_W{1'b0}}, diff} * {{TW{1'b0}}, b1_rem_reg[l]};
            end
        end
    end

    logic               d2_valid;
    logic [1:0][TW-1:0] d2_quo;
    side2_t             d2_side;

    rcvs_div #(.NW(NW2), .DW(REG_W), .QW(TW), .PW($bits(side2_t))) u_div_interp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b2_valid_reg),
        .num_i     (b2_prod_reg),
        .den_i     ({b2_item_reg.a_span, b2_item_reg.t_span}),
        .side_i    ({b2_item_reg, b2_lo_reg[0], b2_lo_reg[1]}),
        .out_valid (d2_valid),
        .quo_o     (d2_quo),
        .rem_o     (),
        .side_o    (d2_side)
    );

    // Speed limits per lane: lane 0 translation, lane 1 yaw.
    logic [1:0][REG_W-1:0] vmax;
    logic [1:0][REG_W-1:0] vmin;
    logic [1:0]            up;
    logic [1:0][REG_W-1:0] dabs;

    always_comb begin
        vmax[0] = cfg.speed_max;
        vmin[0] = cfg.speed_min;
        vmax[1] = cfg.turn_rate_max;
        vmin[1] = cfg.turn_rate_min;
        for (int l = 0; l < 2; l++) begin
            up[l]   = (vmax[l] >= vmin[l]);
            dabs[l] = up[l] ? vmax[l] - vmin[l] : vmin[l] - vmax[l];
        end
    end

    logic                      b3_valid_reg;
    rcvs_item_t                b3_item_reg;
    logic [1:0][REG_W+TW-1:0]  b3_prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b3_valid_reg <= 1'b0;
        end else if (en) begin
            b3_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        logic [1:0][TW-1:0] w;
        if (en) begin
            b3_item_reg <= d2_side.item;
            w[0] = d2_side.lo_t + d2_quo[0];
            w[1] = d2_side.lo_a + d2_quo[1];
            for (int l = 0; l < 2; l++) begin
                b3_prod_reg[l] <= {{TW{1'b0}}, dabs[l]} * {{REG_W{1'b0}}, w[l]};
            end
        end
    end

    logic                  b4_valid_reg;
    rcvs_item_t            b4_item_reg;
    logic [1:0][REG_W-1:0] b4_nv_reg;
    shape_class_t [1:0]    cls;
    logic [1:0][REG_W-1:0] ramp;

    always_comb begin
        logic [REG_W+TW:0] rsum;
        logic [REG_W-1:0]  mag;
        cls[0] = b3_item_reg.t_class;
        cls[1] = b3_item_reg.a_class;
        for (int l = 0; l < 2; l++) begin
            rsum    = {1'b0, b3_prod_reg[l]} + ((REG_W+TW+1)'(1) << (SB - 1));
            mag     = REG_W'(rsum >> SB);
            ramp[l] = up[l] ? vmin[l] + mag : vmin[l] - mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b4_valid_reg <= 1'b0;
        end else if (en) begin
            b4_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b4_item_reg <= b3_item_reg;
            for (int l = 0; l < 2; l++) begin
                case (cls[l])
                    SC_ZERO: b4_nv_reg[l] <= '0;
                    SC_MAX:  b4_nv_reg[l] <= vmax[l];
                    SC_MIN:  b4_nv_reg[l] <= vmin[l];
                    default: b4_nv_reg[l] <= ramp[l];
                endcase
            end
        end
    end

    // Vector rescale: |x| * new / old.
    logic                b5_valid_reg;
    logic [1:0][PW3-1:0] b5_prod_reg;
    logic [DATA_W-1:0]   b5_mag_reg;
    side3_t              b5_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b5_valid_reg <= 1'b0;
        end else if (en) begin
            b5_valid_reg <= b4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b5_prod_reg[0] <= {{REG_W{1'b0}}, b4_item_reg.x_abs}
                            * {{DATA_W{1'b0}}, b4_nv_reg[0]};
            b5_prod_reg[1] <= {{REG_W{1'b0}}, b4_item_reg.y_abs}
                            * {{DATA_W{1'b0}}, b4_nv_reg[0]};
            b5_mag_reg         <= b4_item_reg.mag;
            b5_side_reg.x_neg  <= b4_item_reg.x_neg;
            b5_side_reg.y_neg  <= b4_item_reg.y_neg;
            b5_side_reg.m_zero <= (b4_item_reg.mag == '0);
            b5_side_reg.yaw    <= b4_item_reg.yaw_neg ? (~{1'b0, b4_nv_reg[1]} + 1'b1)
                                                      : {1'b0, b4_nv_reg[1]};
        end
    end

    logic                  d3_valid;
    logic [1:0][REG_W-1:0] d3_quo;
    side3_t                d3_side;

    rcvs_div #(.NW(PW3), .DW(DATA_W), .QW(REG_W), .PW($bits(side3_t))) u_div_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (b5_valid_reg),
        .num_i     (b5_prod_reg),
        .den_i     ({b5_mag_reg, b5_mag_reg}),
        .side_i    (b5_side_reg),
        .out_valid (d3_valid),
        .quo_o     (d3_quo),
        .rem_o     (),
        .side_o    (d3_side)
    );

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_x_reg;
    logic [DATA_W-1:0] out_y_reg;
    logic [DATA_W-1:0] out_yaw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= d3_valid;
        end
    end

    // A zero vector divides by zero above; its quotient is discarded here.
    always_ff @(posedge aclk) begin
        if (en) begin
            if (d3_side.m_zero) begin
                out_x_reg <= '0;
                out_y_reg <= '0;
            end else begin
                out_x_reg <= d3_side.x_neg ? (~{1'b0, d3_quo[0]} + 1'b1) : {1'b0, d3_quo[0]};
                out_y_reg <= d3_side.y_neg ? (~{1'b0, d3_quo[1]} + 1'b1) : {1'b0, d3_quo[1]};
            end
            out_yaw_reg <= d3_side.yaw;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_yaw   = out_yaw_reg;

endmodule

[rtl/core/raised_cosine_velocity_shaper.sv]
// ============================================================================
// raised_cosine_velocity_shaper
// Reshapes a planar velocity and yaw command with a raised-cosine ramp.
// ============================================================================
//
//  Channel  Direction  Handshake                  Content
//  s_       in         s_tvalid / s_tready        vel_x, vel_y, yaw_cmd
//  m_       out        m_tvalid / m_tready        shaped_x, shaped_y, shaped_yaw
//  cfg_     in         cfg_valid / cfg_ready      register index, write data
//
// One command per cycle is sustained while m_tready is high once the table
// is loaded; every stage of both ends is pipelined. The front end holds the
// square root pipeline, the back end the three bit-serial divider pipelines,
// and the queue lies between them.
// After reset all 2^COS_TABLE_BITS + 1 table entries are loaded, during which
// s_tready stays low; configuration writes are taken throughout.
// A stall on m_tready freezes the back end; the queue then absorbs the front.
module raised_cosine_velocity_shaper
    import rcvs_pkg::*;
#(
    parameter int COS_TABLE_BITS = 10,
    parameter int SAMPLE_BITS    = 16,
    parameter int QUEUE_DEPTH    = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [3*DATA_W-1:0] s_tdata,   // vel_x, vel_y, yaw_cmd
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [3*DATA_W-1:0] m_tdata,   // shaped_x, shaped_y, shaped_yaw
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [REG_W-1:0]    cfg_wdata
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dist_high     <= REG_W'(100);
            cfg_reg.dist_low      <= REG_W'(10);
            cfg_reg.speed_max     <= REG_W'(100);
            cfg_reg.speed_min     <= REG_W'(10);
            cfg_reg.turn_rate_max <= REG_W'(100);
            cfg_reg.turn_rate_min <= REG_W'(10);
            cfg_reg.angle_high    <= REG_W'(100);
            cfg_reg.angle_low     <= REG_W'(10);
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DIST_HIGH:     cfg_reg.dist_high     <= cfg_wdata;
                CFG_DIST_LOW:      cfg_reg.dist_low      <= cfg_wdata;
                CFG_SPEED_MAX:     cfg_reg.speed_max     <= cfg_wdata;
                CFG_SPEED_MIN:     cfg_reg.speed_min     <= cfg_wdata;
                CFG_TURN_RATE_MAX: cfg_reg.turn_rate_max <= cfg_wdata;
                CFG_TURN_RATE_MIN: cfg_reg.turn_rate_min <= cfg_wdata;
                CFG_ANGLE_HIGH:    cfg_reg.angle_high    <= cfg_wdata;
                CFG_ANGLE_LOW:     cfg_reg.angle_low     <= cfg_wdata;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    logic       table_ready;
    logic       front_ready;
    logic       front_valid;
    rcvs_item_t front_item;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    rcvs_item_t q_item;

    assign s_tready = front_ready && table_ready;

    rcvs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid && table_ready),
        .in_ready  (front_ready),
        .in_x      (s_tdata[DATA_W-1:0]),
        .in_y      (s_tdata[2*DATA_W-1:DATA_W]),
        .in_yaw    (s_tdata[3*DATA_W-1:2*DATA_W]),
        .out_valid (front_valid),
        .out_ready (!q_full),
        .out_item  (front_item)
    );

    rcvs_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (front_valid),
        .din     (front_item),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_item),
        .empty   (q_empty)
    );

    rcvs_back #(.CB(COS_TABLE_BITS), .SB(SAMPLE_BITS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .table_ready (table_ready),
        .q_empty     (q_empty),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_x       (m_tdata[DATA_W-1:0]),
        .out_y       (m_tdata[2*DATA_W-1:DATA_W]),
        .out_yaw     (m_tdata[3*DATA_W-1:2*DATA_W])
    );

endmodule
